>>> rtl/lpcd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the length-prefixed cobs deframer
package lpcd_pkg;

  localparam logic [7:0] DELIM       = 8'h00;
  localparam logic [7:0] CODE_FULL   = 8'hff;
  localparam logic [7:0] DUP_BIT     = 8'h80;
  localparam logic [7:0] LEN_HI_MASK = 8'h7f;

  localparam int unsigned LEN_W = 15;

  typedef struct packed {
    logic [7:0]       out_byte;
    logic             byte_valid;
    logic             frame_end;
    logic             frame_error;
    logic             is_duplicate;
    logic [LEN_W-1:0] decoded_length;
  } lpcd_result_t;

endpackage

>>> rtl/length_prefixed_cobs_deframer.sv
`timescale 1ns / 1ps
// top level of the length-prefixed cobs deframer
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------------------
//  input    | in_valid / in_stall  | rx_byte
//  output   | out_valid / out_stall| out_byte, byte_valid, frame_end,
//           |                      | frame_error, is_duplicate, decoded_length
//
// one link byte per cycle unless in_stall; a result reaches out_valid the
// cycle after its request is taken unless it must wait in the skid entry
// the framing state updates in the same cycle the byte is taken
// rst is synchronous: hunting for a delimiter, no result held
// a one-entry skid stage lets a byte in while a result waits; in_stall
// rises only when both the result register and the skid entry are full
module length_prefixed_cobs_deframer import lpcd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_byte,
  output logic             byte_valid,
  output logic             frame_end,
  output logic             frame_error,
  output logic             is_duplicate,
  output logic [LEN_W-1:0] decoded_length
);

  logic         in_fire;
  logic         res_valid;
  lpcd_result_t res;
  lpcd_result_t held;

  // request taken whenever the skid entry is free
  assign in_fire = in_valid && !in_stall;

  // framing state and decode step
  lpcd_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (in_fire),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register plus skid entry
  lpcd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (held)
  );

  assign out_byte       = held.out_byte;
  assign byte_valid     = held.byte_valid;
  assign frame_end      = held.frame_end;
  assign frame_error    = held.frame_error;
  assign is_duplicate   = held.is_duplicate;
  assign decoded_length = held.decoded_length;

  // the skid entry only fills behind a held result
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("skid entry full with empty result register");

  // an aborted frame carries no byte and closes the frame
  a_error_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_error) |-> (frame_end && !byte_valid))
    else $error("error result without frame end");

  // nothing held right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result pending after reset");

endmodule

>>> rtl/lpcd_core.sv
`timescale 1ns / 1ps
// framing state and per-byte cobs decode step
module lpcd_core import lpcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   rx_byte,
  output logic         res_valid,
  output lpcd_result_t res
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_LEN_LO  = 2'd1,
    PH_LEN_HI  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  phase_t           phase, phase_next;
  logic [7:0]       length_low, length_low_next;
  logic [LEN_W-1:0] bytes_left, bytes_left_next;
  logic [7:0]       block_left, block_left_next;
  logic             prev_code_full, prev_code_full_next;
  logic             duplicate_flag, duplicate_flag_next;
  logic [LEN_W-1:0] decoded_count, decoded_count_next;

  logic [LEN_W-1:0] hdr_len;
  logic [LEN_W-1:0] left_dec;
  logic             last;
  logic             hit;
  logic [7:0]       r_byte;
  logic             r_bvalid, r_end, r_err;

  assign hdr_len  = {rx_byte[6:0] & LEN_HI_MASK[6:0], length_low};
  assign left_dec = bytes_left - LEN_W'(1);
  assign last     = (left_dec == '0);

  always_comb begin
    phase_next          = phase;
    length_low_next     = length_low;
    bytes_left_next     = bytes_left;
    block_left_next     = block_left;
    prev_code_full_next = prev_code_full;
    duplicate_flag_next = duplicate_flag;
    decoded_count_next  = decoded_count;
    hit      = 1'b0;
    r_byte   = 8'h00;
    r_bvalid = 1'b0;
    r_end    = 1'b0;
    r_err    = 1'b0;
    case (phase)
      PH_HUNT: begin
        if (rx_byte == DELIM) phase_next = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        length_low_next = rx_byte;
        phase_next      = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        duplicate_flag_next = ((rx_byte & DUP_BIT) == 8'h00);
        bytes_left_next     = hdr_len;
        block_left_next     = 8'h00;
        prev_code_full_next = 1'b1;
        decoded_count_next  = '0;
        if (hdr_len == '0) begin
          phase_next = PH_HUNT;
          hit        = 1'b1;
          r_end      = 1'b1;
        end else begin
          phase_next = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next = left_dec;
        if (block_left != 8'h00) begin
          // data byte inside a block
          block_left_next    = block_left - 8'd1;
          decoded_count_next = decoded_count + LEN_W'(1);
          if (last) phase_next = PH_HUNT;
          hit      = 1'b1;
          r_byte   = rx_byte;
          r_bvalid = 1'b1;
          r_end    = last;
        end else if (rx_byte == DELIM) begin
          // zero code byte aborts the frame
          phase_next      = PH_HUNT;
          bytes_left_next = '0;
          hit             = 1'b1;
          r_end           = 1'b1;
          r_err           = 1'b1;
        end else begin
          prev_code_full_next = (rx_byte == CODE_FULL);
          block_left_next     = rx_byte - 8'd1;
          if (last) phase_next = PH_HUNT;
          if (!prev_code_full) begin
            // implied zero from the previous short block
            decoded_count_next = decoded_count + LEN_W'(1);
            hit      = 1'b1;
            r_bvalid = 1'b1;
            r_end    = last;
          end else if (last) begin
            hit   = 1'b1;
            r_end = 1'b1;
          end
        end
      end
      default: begin
        phase_next = PH_HUNT;
      end
    endcase
  end

  assign res_valid          = step && hit;
  assign res.out_byte       = r_byte;
  assign res.byte_valid     = r_bvalid;
  assign res.frame_end      = r_end;
  assign res.frame_error    = r_err;
  assign res.is_duplicate   = duplicate_flag_next;
  assign res.decoded_length = decoded_count_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      length_low     <= 8'h00;
      bytes_left     <= '0;
      block_left     <= 8'h00;
      prev_code_full <= 1'b1;
      duplicate_flag <= 1'b0;
      decoded_count  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      length_low     <= length_low_next;
      bytes_left     <= bytes_left_next;
      block_left     <= block_left_next;
      prev_code_full <= prev_code_full_next;
      duplicate_flag <= duplicate_flag_next;
      decoded_count  <= decoded_count_next;
    end
  end

endmodule

>>> rtl/lpcd_skid.sv
`timescale 1ns / 1ps
// result register with one skid entry
module lpcd_skid import lpcd_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lpcd_result_t push_data,
  output logic         full,
  output logic         out_valid,
  input  logic         out_stall,
  output lpcd_result_t out_data
);

  logic         skid_valid;
  lpcd_result_t skid_data;
  logic         out_fire;

  assign out_fire = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_fire) begin
        out_data  <= push_data;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= push_data;
        skid_valid <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

endmodule
